// ===== sv/descending_stable_insertion_sorter_core_defines.svh =====
// Assertion macros shared by the sorter's checker.
`ifndef DESCENDING_STABLE_INSERTION_SORTER_CORE_DEFINES_SVH
`define DESCENDING_STABLE_INSERTION_SORTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define DSIS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorter same-cycle check failed");

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define DSIS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorter next-cycle check failed");

`endif

// ===== sv/dsis_pkg.sv =====
// Shared constants and types of the descending stable insertion sorter.
package dsis_pkg;

	localparam int CAPACITY = 32;
	localparam int ID_W     = 8;
	localparam int KEY_W    = 31;

	typedef struct packed {
		logic             valid;
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} cell_data_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} cell_ctl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage

// ===== sv/dsis_cell.sv =====
// One slot of the insertion chain: holds an entry, takes a new one or a neighbor's.
module dsis_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dsis_pkg::cell_ctl_t       ctl,
	input  logic [dsis_pkg::ID_W-1:0]  new_id,
	input  logic [dsis_pkg::KEY_W-1:0] new_key,
	input  logic                      prev_less,
	input  dsis_pkg::cell_data_t      prev,
	input  dsis_pkg::cell_data_t      next,
	output logic                      less,
	output dsis_pkg::cell_data_t      data
);
	import dsis_pkg::*;

	logic             valid_q;
	logic [ID_W-1:0]  id_q;
	logic [KEY_W-1:0] key_q;
	logic             shift_in;
	logic             take_new;

	// A new word goes after stored entries with an equal key, so only a strictly
	// smaller key, or an empty slot, gives way.
	assign less     = !valid_q || (key_q < new_key);
	assign shift_in = ctl.insert && less && prev_less;
	assign take_new = ctl.insert && less && !prev_less;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.drain) begin
			valid_q <= next.valid;
		end else if (shift_in) begin
			valid_q <= prev.valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			id_q  <= next.id;
			key_q <= next.key;
		end else if (shift_in) begin
			id_q  <= prev.id;
			key_q <= prev.key;
		end else if (take_new) begin
			id_q  <= new_id;
			key_q <= new_key;
		end
	end

	assign data = '{valid: valid_q, id: id_q, key: key_q};

endmodule

// ===== sv/dsis_ctrl.sv =====
// Load and drain sequencing of the sorter, with the overflow flag.
module dsis_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                batch_end,
	input  logic                full,
	input  logic                last,
	output logic                busy,
	output logic                ovf,
	output dsis_pkg::cell_ctl_t ctl
);
	import dsis_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   ovf_q;
	logic   accept;

	assign accept = start && (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && batch_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (last) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		busy       = 1'b0;
		ctl.insert = 1'b0;
		ctl.drain  = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				ctl.insert = start && !full;
			end
			ST_DRAIN: begin
				busy      = 1'b1;
				ctl.drain = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && full) begin
				ovf_q <= 1'b1;
			end else if ((state_q == ST_DRAIN) && last) begin
				ovf_q <= 1'b0;
			end
		end
	end

	assign ovf = ovf_q;

endmodule

// ===== sv/descending_stable_insertion_sorter_core.sv =====
// Latency: a word with batch_end gives its first result in the cycle after it is taken.
// Throughput: one word per cycle while loading; the results of a batch then stream out back
// to back with busy high, the chain shifting one slot toward slot zero for each result.
// Results cannot be stalled. Reset (arst_n low) empties every slot and clears overflow.
// Entries beyond CAPACITY are dropped and flagged on the batch's results.
module descending_stable_insertion_sorter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [dsis_pkg::ID_W-1:0]  entry_id,
	input  logic [dsis_pkg::KEY_W-1:0] sort_key,
	input  logic                       batch_end,
	output logic                       result_valid,
	output logic [dsis_pkg::ID_W-1:0]  out_id,
	output logic [dsis_pkg::KEY_W-1:0] out_key,
	output logic                       overflowed,
	output logic                       final_entry
);
	import dsis_pkg::*;

	cell_data_t cells [CAPACITY];
	logic       less  [CAPACITY];
	cell_ctl_t  ctl;
	logic       full;
	logic       last;
	logic       ovf;

	// Valid slots are always packed from slot zero in descending key order.
	assign full = cells[CAPACITY-1].valid;
	assign last = !cells[1].valid;

	dsis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.batch_end (batch_end),
		.full      (full),
		.last      (last),
		.busy      (busy),
		.ovf       (ovf),
		.ctl       (ctl)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic       prev_less;
		cell_data_t prev;
		cell_data_t next;

		if (i == 0) begin : g_head
			assign prev_less = 1'b0;
			assign prev      = '0;
		end else begin : g_body
			assign prev_less = less[i-1];
			assign prev      = cells[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next = '0;
		end else begin : g_inner
			assign next = cells[i+1];
		end

		dsis_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_id    (entry_id),
			.new_key   (sort_key),
			.prev_less (prev_less),
			.prev      (prev),
			.next      (next),
			.less      (less[i]),
			.data      (cells[i])
		);
	end

	assign result_valid = ctl.drain;
	assign out_id       = cells[0].id;
	assign out_key      = cells[0].key;
	assign overflowed   = ovf;
	assign final_entry  = ctl.drain && last;

endmodule

// ===== sv/dsis_checker.sv =====
// Port-level checks of the sorter's result sequencing, bound to the top level.
`include "descending_stable_insertion_sorter_core_defines.svh"

module dsis_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic batch_end,
	input logic result_valid,
	input logic overflowed,
	input logic final_entry
);

	`DSIS_ASSERT_NOW(a_result_only_busy, result_valid, busy)
	`DSIS_ASSERT_NEXT(a_batch_end_drains, start && !busy && batch_end, result_valid)
	`DSIS_ASSERT_NEXT(a_final_frees, result_valid && final_entry, !busy)
	`DSIS_ASSERT_NEXT(a_run_unbroken, result_valid && !final_entry, result_valid && $stable(overflowed))

endmodule

bind descending_stable_insertion_sorter_core dsis_checker u_dsis_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.batch_end    (batch_end),
	.result_valid (result_valid),
	.overflowed   (overflowed),
	.final_entry  (final_entry)
);
